/* hdl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers used by the checker modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge, reset included.
`define ASSERT_CLK(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("assertion failed");

// Property checked only while reset is low.
`define ASSERT_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

`endif

/* hdl/ricrc_pkg.sv */
// ---------------------------------------------------------------------------
// ricrc_pkg
// Widths, constants and bit-level helpers for the reversed/inverted CRC-16.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ricrc_pkg;

   localparam int BYTE_W        = 8;
   localparam int CRC_W         = 16;
   localparam int CNT_W         = 5;
   localparam int MSG_BYTES_DEF = 21;

   localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

   // Bit-reverse a byte, then complement it
   function automatic logic [BYTE_W-1:0] flip_byte(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] r;
      for (int k = 0; k < BYTE_W; k++) begin
         r[BYTE_W-1-k] = b[k];
      end
      return ~r;
   endfunction

   // Fold one byte into the CRC, MSB first, eight shift/xor steps
   function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] c;
      c = crc ^ {b, {(CRC_W-BYTE_W){1'b0}}};
      for (int k = 0; k < BYTE_W; k++) begin
         if (c[CRC_W-1]) begin
            c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[CRC_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

/* hdl/ricrc_fold.sv */
// ---------------------------------------------------------------------------
// ricrc_fold
// Combinational CRC update: reverse and invert one raw byte, fold it in.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ricrc_fold (
   input  logic [ricrc_pkg::CRC_W-1:0]  crc,
   input  logic [ricrc_pkg::BYTE_W-1:0] raw_byte,
   output logic [ricrc_pkg::CRC_W-1:0]  crc_next
);
   import ricrc_pkg::*;

   logic [BYTE_W-1:0] flipped;

   // Byte conditioning, then the 0x1021 shift register over eight bits
   assign flipped  = flip_byte(raw_byte);
   assign crc_next = crc_fold(crc, flipped);

endmodule

/* hdl/reversed_inverted_crc16_check.sv */
// ---------------------------------------------------------------------------
// reversed_inverted_crc16_check
// Streaming CRC-16 (poly 0x1021, zero init) over fixed-length messages.
// ---------------------------------------------------------------------------
// Usage:
//   req channel carries one message byte per request (req_data_byte). Each
//   byte is bit-reversed and complemented before it enters the CRC.
//   After MESSAGE_BYTES requests, one response on the rsp channel carries
//   the CRC high and low bytes; CRC and byte count then restart at zero.
//   Bytes other than the last of a message produce no response.
// Path: an accepted request is registered in the input register, then
//   folded into the CRC register; the last byte of a message loads the
//   output register, which drives rsp_valid.
// Throughput: one byte per cycle unless a held response stalls the
//   request side; the byte fold (eight shift/xor steps) is combinational.
// Stall: a held response stalls the request side only when the byte in
//   the input register completes another message; other bytes keep flowing.
// Reset: synchronous; clears CRC, byte count and both valid flags.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module reversed_inverted_crc16_check #(
   parameter int MESSAGE_BYTES = ricrc_pkg::MSG_BYTES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [ricrc_pkg::BYTE_W-1:0] req_data_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [ricrc_pkg::BYTE_W-1:0] rsp_check_high,
   output logic [ricrc_pkg::BYTE_W-1:0] rsp_check_low
);
   import ricrc_pkg::*;

   localparam logic [CNT_W:0] LAST_CNT = (CNT_W+1)'(MESSAGE_BYTES);

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff,  in_byte_in;
   logic [CRC_W-1:0]  crc_ff,      crc_in;
   logic [CNT_W-1:0]  count_ff,    count_in;
   logic              out_valid_ff, out_valid_in;
   logic [CRC_W-1:0]  out_crc_ff,  out_crc_in;

   logic [CRC_W-1:0]  crc_next;
   logic [CNT_W:0]    count_next;
   logic              last_byte;
   logic              advance;
   logic              accept;

   ricrc_fold u_fold (
      .crc      (crc_ff),
      .raw_byte (in_byte_ff),
      .crc_next (crc_next)
   );

   // End-of-message detection on the byte in the input register
   assign count_next = {1'b0, count_ff} + (CNT_W+1)'(1);
   assign last_byte  = (count_next >= LAST_CNT);

   // Byte moves on unless it ends a message and the result slot is held
   assign advance   = in_valid_ff && (!last_byte || !out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   // Next-state logic
   always_comb begin
      in_valid_in  = in_valid_ff;
      in_byte_in   = in_byte_ff;
      crc_in       = crc_ff;
      count_in     = count_ff;
      out_valid_in = out_valid_ff;
      out_crc_in   = out_crc_ff;

      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end

      if (advance) begin
         in_valid_in = 1'b0;
         if (last_byte) begin
            crc_in       = '0;
            count_in     = '0;
            out_valid_in = 1'b1;
            out_crc_in   = crc_next;
         end else begin
            crc_in   = crc_next;
            count_in = count_next[CNT_W-1:0];
         end
      end

      if (accept) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_data_byte;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         crc_ff       <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         crc_ff       <= crc_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      out_crc_ff <= out_crc_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_check_high = out_crc_ff[CRC_W-1 -: BYTE_W];
   assign rsp_check_low  = out_crc_ff[BYTE_W-1:0];

endmodule

/* hdl/ricrc_checker.sv */
// ---------------------------------------------------------------------------
// ricrc_checker
// Port-level assertions for the CRC-16 check block, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ricrc_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic [ricrc_pkg::BYTE_W-1:0] req_data_byte,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [ricrc_pkg::BYTE_W-1:0] rsp_check_high,
   input logic [ricrc_pkg::BYTE_W-1:0] rsp_check_low
);

   // No response may survive reset
   `ASSERT_CLK(a_reset_clears_rsp, clock, reset |=> !rsp_valid)

   // A stalled response keeps its checksum
   `ASSERT_RST(a_rsp_hold, clock, reset,
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_check_high) && $stable(rsp_check_low))

   // Request backpressure only comes from a held response
   `ASSERT_RST(a_stall_cause, clock, reset, req_stall |-> rsp_valid && rsp_stall)

   // With the result slot free the request side never stalls
   `ASSERT_RST(a_free_no_stall, clock, reset, !rsp_valid |-> !req_stall)

   // An offered request carries a defined byte
   `ASSERT_RST(a_req_known, clock, reset, req_valid |-> !$isunknown(req_data_byte))

endmodule

bind reversed_inverted_crc16_check ricrc_checker u_ricrc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_data_byte  (req_data_byte),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_check_high (rsp_check_high),
   .rsp_check_low  (rsp_check_low)
);
